// File: src/msa_pkg.sv
package msa_pkg;

  // Sizes and widths fixed by the item and register formats
  localparam int unsigned MaxWidthDefault = 2048;
  localparam int unsigned MaxHeight       = 2048;
  localparam int unsigned PixW            = 8;
  localparam int unsigned SizeRegW        = 12;
  localparam int unsigned RowW            = 11;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 12;
  localparam int unsigned NumW            = 10;
  localparam int unsigned DenW            = 3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight    = 2'd2;

  // Register reset values
  localparam logic [PixW-1:0]     ThresholdReset = 8'd200;
  localparam logic [SizeRegW-1:0] WidthReset     = 12'd640;
  localparam logic [SizeRegW-1:0] HeightReset    = 12'd360;

  // floor(n / 3) == (n * 683) >> 11 for every n below 1024
  localparam logic [NumW-1:0] RecipThree = 10'd683;
  localparam int unsigned     RecipShift = 11;

  typedef struct packed {
    logic [PixW-1:0] frame_a_pixel;
    logic [PixW-1:0] frame_b_pixel;
    logic [PixW-1:0] frame_c_pixel;
    logic            frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            row_end;
    logic            frame_end;
  } out_item_t;

  // One store entry: the top row pair of a 2x2 block
  typedef struct packed {
    logic [8:0] all_sum;
    logic [1:0] def_cnt;
    logic [8:0] def_sum;
  } half_block_t;

  // Quotient by a divisor of one to four, truncated
  function automatic logic [PixW-1:0] div_small(input logic [NumW-1:0] num,
                                                input logic [DenW-1:0] den);
    logic [2*NumW-1:0] prod;
    logic [PixW-1:0]   quo;
    prod = num * RecipThree;
    case (den)
      3'd1:    quo = num[PixW-1:0];
      3'd2:    quo = num[PixW:1];
      3'd3:    quo = prod[RecipShift+PixW-1:RecipShift];
      3'd4:    quo = num[PixW+1:2];
      default: quo = '0;
    endcase
    return quo;
  endfunction

endpackage

// File: src/masked_spatiotemporal_average.sv
// Channel | direction | handshake                   | payload
// cfg     | in        | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o     | in_i (three grey values, frame_start)
// out     | out       | out_valid_o / out_ready_i   | out_o (out_pixel, row_end, frame_end)
//
// One item is taken per cycle while no result waits on out_ready_i. The bottom-right item
// of a 2x2 block passes five register stages, the last driving out_valid_o: item capture,
// temporal divide, half-block store access (write on top rows, read on bottom rows),
// block sum and block divide.
// Reset clears the position counters, the left pixel and all valid bits; the store
// needs no clearing pass, as every bottom-row read follows the matching top-row write.
// The whole pipeline holds while a result waits on out_ready_i.
module masked_spatiotemporal_average #(
  parameter int unsigned MAX_WIDTH = msa_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [msa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  msa_pkg::in_item_t              in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output msa_pkg::out_item_t             out_o
);

  localparam int unsigned CntW       = $clog2(MAX_WIDTH);
  localparam int unsigned SizeW      = CntW + 1;
  localparam int unsigned CmpW       = (SizeW > msa_pkg::SizeRegW) ? SizeW : msa_pkg::SizeRegW;
  localparam int unsigned StoreDepth = MAX_WIDTH / 2;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned HW         = msa_pkg::SizeRegW;

  typedef enum logic [1:0] {
    RoleLeft,
    RoleTop,
    RoleBottom
  } role_e;

  // Configuration registers
  logic [msa_pkg::PixW-1:0] thr_q;
  logic [HW-1:0]            fwidth_q;
  logic [HW-1:0]            fheight_q;

  // Position counters and left pixel
  logic [CntW-1:0]          col_q, col_d;
  logic [msa_pkg::RowW-1:0] row_q, row_d;
  logic [msa_pkg::PixW-1:0] left_q;

  // Pipeline
  logic adv, acc;

  logic                      s1_v_q;
  role_e                     s1_role_q;
  logic [IdxW-1:0]           s1_idx_q;
  logic                      s1_rend_q, s1_fend_q;
  logic [msa_pkg::NumW-1:0]  s1_num_q;
  logic [1:0]                s1_den_q;

  logic                      s2_v_q;
  role_e                     s2_role_q;
  logic [IdxW-1:0]           s2_idx_q;
  logic                      s2_rend_q, s2_fend_q;
  logic [msa_pkg::PixW-1:0]  s2_t_q;

  logic                      s3_v_q;
  logic                      s3_rend_q, s3_fend_q;
  logic [8:0]                s3_psum_q, s3_pall_q;
  logic [1:0]                s3_pcnt_q;
  msa_pkg::half_block_t      s3_entry_q;

  logic                      s4_v_q;
  logic                      s4_rend_q, s4_fend_q;
  logic [msa_pkg::NumW-1:0]  s4_num_q;
  logic [msa_pkg::DenW-1:0]  s4_den_q;

  logic                      out_valid_q;
  msa_pkg::out_item_t        out_q;

  msa_pkg::half_block_t      store_mem [StoreDepth];

  // ---------------------------------------------------------------------------
  // Frame geometry: clamp sizes into range, round down to even
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0]  fw_ext, w_cmp;
  logic [SizeW-1:0] w, w_even;
  logic [HW-1:0]    h, h_even;

  always_comb begin
    fw_ext = CmpW'(fwidth_q);
    if (fw_ext < CmpW'(2)) begin
      w_cmp = CmpW'(2);
    end else if (fw_ext > CmpW'(MAX_WIDTH)) begin
      w_cmp = CmpW'(MAX_WIDTH);
    end else begin
      w_cmp = fw_ext;
    end
    w      = SizeW'(w_cmp);
    w_even = {w[SizeW-1:1], 1'b0};

    if (fheight_q < HW'(2)) begin
      h = HW'(2);
    end else if (fheight_q > HW'(msa_pkg::MaxHeight)) begin
      h = HW'(msa_pkg::MaxHeight);
    end else begin
      h = fheight_q;
    end
    h_even = {h[HW-1:1], 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Input side: position decode and temporal masked sums
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]          col;
  logic [msa_pkg::RowW-1:0] row;
  logic [SizeW-1:0]         col_inc;
  logic [HW-1:0]            row_inc;
  logic                     in_area, rend, fend;
  role_e                    role;
  logic [IdxW-1:0]          idx;
  logic                     da, db, dc;
  logic [msa_pkg::NumW-1:0] dsum3, all3, num1;
  logic [1:0]               dcnt3, den1;

  always_comb begin
    col = in_i.frame_start ? '0 : col_q;
    row = in_i.frame_start ? '0 : row_q;

    in_area = (SizeW'(col) < w_even) && (HW'(row) < h_even);
    rend    = (SizeW'(col) == w_even - SizeW'(1));
    fend    = rend && (HW'(row) == h_even - HW'(1));
    idx     = IdxW'(col >> 1);

    if (!col[0]) begin
      role = RoleLeft;
    end else if (!row[0]) begin
      role = RoleTop;
    end else begin
      role = RoleBottom;
    end

    // Advance; wrap at the clamped size
    col_inc = SizeW'(col) + SizeW'(1);
    row_inc = HW'(row) + HW'(1);
    if (col_inc >= w) begin
      col_d = '0;
      row_d = (row_inc >= h) ? '0 : row_inc[msa_pkg::RowW-1:0];
    end else begin
      col_d = col_inc[CntW-1:0];
      row_d = row;
    end

    da = in_i.frame_a_pixel < thr_q;
    db = in_i.frame_b_pixel < thr_q;
    dc = in_i.frame_c_pixel < thr_q;
    dsum3 = (da ? msa_pkg::NumW'(in_i.frame_a_pixel) : '0)
          + (db ? msa_pkg::NumW'(in_i.frame_b_pixel) : '0)
          + (dc ? msa_pkg::NumW'(in_i.frame_c_pixel) : '0);
    dcnt3 = 2'(da) + 2'(db) + 2'(dc);
    all3  = msa_pkg::NumW'(in_i.frame_a_pixel) + msa_pkg::NumW'(in_i.frame_b_pixel)
          + msa_pkg::NumW'(in_i.frame_c_pixel);

    // Fall back to the plain average when nothing is defined
    num1 = (dcnt3 == 2'd0) ? all3 : dsum3;
    den1 = (dcnt3 == 2'd0) ? 2'd3 : dcnt3;
  end

  // ---------------------------------------------------------------------------
  // Store stage: pair the left pixel with this one
  // ---------------------------------------------------------------------------
  logic       dl, dt;
  logic [8:0] psum, pall;
  logic [1:0] pcnt;

  always_comb begin
    dl   = left_q < thr_q;
    dt   = s2_t_q < thr_q;
    psum = (dl ? 9'(left_q) : 9'd0) + (dt ? 9'(s2_t_q) : 9'd0);
    pcnt = 2'(dl) + 2'(dt);
    pall = 9'(left_q) + 9'(s2_t_q);
  end

  // ---------------------------------------------------------------------------
  // Block stage: add the stored top pair
  // ---------------------------------------------------------------------------
  logic [msa_pkg::NumW-1:0] dsum4, all4, num4;
  logic [msa_pkg::DenW-1:0] dcnt4, den4;

  always_comb begin
    dsum4 = msa_pkg::NumW'(s3_entry_q.def_sum) + msa_pkg::NumW'(s3_psum_q);
    dcnt4 = msa_pkg::DenW'(s3_entry_q.def_cnt) + msa_pkg::DenW'(s3_pcnt_q);
    all4  = msa_pkg::NumW'(s3_entry_q.all_sum) + msa_pkg::NumW'(s3_pall_q);
    num4  = (dcnt4 == '0) ? all4 : dsum4;
    den4  = (dcnt4 == '0) ? msa_pkg::DenW'(4) : dcnt4;
  end

  // Hold everything while a result waits
  assign adv        = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && adv;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= msa_pkg::ThresholdReset;
      fwidth_q    <= msa_pkg::WidthReset;
      fheight_q   <= msa_pkg::HeightReset;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          msa_pkg::CfgThreshold: thr_q     <= cfg_wdata_i[msa_pkg::PixW-1:0];
          msa_pkg::CfgWidth:     fwidth_q  <= cfg_wdata_i[HW-1:0];
          msa_pkg::CfgHeight:    fheight_q <= cfg_wdata_i[HW-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        if (s2_v_q && s2_role_q == RoleLeft) begin
          left_q <= s2_t_q;
        end
        s1_v_q      <= acc && in_area;
        s2_v_q      <= s1_v_q;
        s3_v_q      <= s2_v_q && (s2_role_q == RoleBottom);
        s4_v_q      <= s3_v_q;
        out_valid_q <= s4_v_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_role_q <= role;
      s1_idx_q  <= idx;
      s1_rend_q <= rend;
      s1_fend_q <= fend;
      s1_num_q  <= num1;
      s1_den_q  <= den1;

      s2_role_q <= s1_role_q;
      s2_idx_q  <= s1_idx_q;
      s2_rend_q <= s1_rend_q;
      s2_fend_q <= s1_fend_q;
      s2_t_q    <= msa_pkg::div_small(s1_num_q, {1'b0, s1_den_q});

      s3_rend_q <= s2_rend_q;
      s3_fend_q <= s2_fend_q;
      s3_psum_q <= psum;
      s3_pcnt_q <= pcnt;
      s3_pall_q <= pall;

      s4_rend_q <= s3_rend_q;
      s4_fend_q <= s3_fend_q;
      s4_num_q  <= num4;
      s4_den_q  <= den4;

      out_q.out_pixel <= msa_pkg::div_small(s4_num_q, s4_den_q);
      out_q.row_end   <= s4_rend_q;
      out_q.frame_end <= s4_fend_q;
    end
  end

  // Half-block store: write top pairs, read on bottom rows
  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      if (s2_role_q == RoleTop) begin
        store_mem[s2_idx_q] <= '{all_sum: pall, def_cnt: pcnt, def_sum: psum};
      end
      if (s2_role_q == RoleBottom) begin
        s3_entry_q <= store_mem[s2_idx_q];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_end |-> out_o.row_end)
    else $error("frame_end without row_end");

  a_result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s4_v_q))
    else $error("result appeared without a block in the last stage");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> s4_den_q != '0)
    else $error("zero divisor in block stage");

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SizeW'(col_q) < SizeW'(MAX_WIDTH))
    else $error("column counter beyond maximum width");
`endif

endmodule
